// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent property checks that compile away when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// clocked implication check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// combinational invariant sampled at the clock edge
`define ASSERT_INV(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_INV(label, clk, rst, expr, msg)
`endif

`endif

// File: hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and field widths of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int POS_W      = 7;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = 7;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_READ   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type op;
      logic        rd_load;
      logic        rd_en;
   } cell_ctl_type;

endpackage

// File: hdl/ple_if.sv
// ----------------------------------------------------------------------------
// ple channel interfaces
// valid/ready channels for requests and responses of the list engine
// ----------------------------------------------------------------------------
interface ple_req_if
   import ple_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [POS_W-1:0]      position;
   logic [VALUE_W-1:0]    value;

   modport source (output valid, req_type, position, value, input ready);
   modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface ple_rsp_if
   import ple_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  read_value;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    length;
   logic                is_empty;

   modport source (output valid, read_value, status, length, is_empty, input ready);
   modport sink   (input valid, read_value, status, length, is_empty, output ready);
endinterface

// File: hdl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds an entry and shifts with its neighbors on insert/delete
// ----------------------------------------------------------------------------
module ple_cell
   import ple_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int IDX_W      = 6,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [IDX_W-1:0]      at,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [DATA_WIDTH-1:0] prev_data,
   input  logic [DATA_WIDTH-1:0] next_data,
   output logic [DATA_WIDTH-1:0] data,
   output logic [DATA_WIDTH-1:0] rd_data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;
   logic                  match;
   logic                  after;

   assign match = (at == MY_IDX);
   assign after = (MY_IDX > at);

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (after) begin
               data_in = prev_data;
            end else if (match) begin
               data_in = wr_data;
            end
         end
         CELL_DELETE: begin
            if (after || match) begin
               data_in = next_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   // masked read leaf, or-ed together at the top
   always_comb begin
      rd_in = rd_ff;
      if (ctl.rd_load) begin
         rd_in = (ctl.rd_en && match) ? data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data    = data_ff;
   assign rd_data = rd_ff;

endmodule

// File: hdl/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// bounded ordered list with 1-based append, insert, delete and read
// ----------------------------------------------------------------------------
// Requests arrive on req_if (valid/ready): req_type, position and value.
// Each transaction yields exactly one response on rsp_if with the read word,
// a status (ok, bad position, full), the length after the request and an
// empty flag.
// The list lives in a chain of CAPACITY cells; an insert or delete moves all
// later entries one cell at once, each cell taking its neighbor.
// An accepted request is registered and moves to the execute state, where the
// chain shifts and the read word is loaded into the cell leaves; the done state
// then moves the read word from the leaves into the response register. No new
// request is taken while a request is in the execute state.
// A finished response waits in the output register while the receiver
// stalls; the next request is taken as soon as that register frees up.
// Reset (synchronous, active high) empties the list and drops any pending
// response; cell contents are left as they were, entries beyond the length
// are never read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_engine_core
   import ple_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_if,
   ple_rsp_if.source rsp_if
);

   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int EXT_W   = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int LEXT_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

   state_type             state_ff, state_in;
   req_kind_type          op_ff, op_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   status_type            status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_read_value_ff, rsp_read_value_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]      rsp_length_ff, rsp_length_in;
   logic                  rsp_is_empty_ff, rsp_is_empty_in;

   logic                  req_accept;
   logic                  rsp_load;
   cell_ctl_type          ctl;
   logic [IDX_W-1:0]      at;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      at_ext;
   logic                  pos_ok;
   logic                  full;
   logic [EXT_W-1:0]      val_ext;
   logic [EXT_W-1:0]      rd_ext;
   logic [LEXT_W-1:0]     len_ext;
   logic [DATA_WIDTH-1:0] rd_or;

   logic [DATA_WIDTH-1:0] data_w [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_w   [CAPACITY];

   // handshake
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = (state_ff == S_IDLE) || rsp_load;
   assign req_accept   = req_if.valid && req_if.ready;

   // decode against the current length
   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);
   assign at_ext  = pos_ext - CMP_W'(1);
   assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign full    = (cnt_ext == CAP_C);
   assign val_ext = EXT_W'(req_if.value);

   always_comb begin
      ctl         = '{op: CELL_HOLD, rd_load: 1'b0, rd_en: 1'b0};
      at          = at_ext[IDX_W-1:0];
      count_in    = count_ff;
      status_in   = status_ff;
      if (state_ff == S_EXEC) begin
         ctl.rd_load = 1'b1;
         status_in   = ST_OK;
         unique case (op_ff)
            REQ_APPEND: begin
               // append is an insert at the tail slot
               at = cnt_ext[IDX_W-1:0];
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_INSERT: begin
               if (!pos_ok) begin
                  status_in = ST_BAD_POS;
               end else if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_DELETE: begin
               if (!pos_ok) begin
                  status_in = ST_BAD_POS;
               end else begin
                  ctl.op   = CELL_DELETE;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            REQ_READ: begin
               if (!pos_ok) begin
                  status_in = ST_BAD_POS;
               end else begin
                  ctl.rd_en = 1'b1;
               end
            end
            default: status_in = ST_OK;
         endcase
      end
   end

   // state machine
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      pos_in   = pos_ff;
      value_in = value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = S_DONE;
         S_DONE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end else if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (req_accept) begin
         op_in    = req_kind_type'(req_if.req_type);
         pos_in   = req_if.position;
         value_in = val_ext[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   // cell chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_d;
      logic [DATA_WIDTH-1:0] next_d;
      if (g == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_prev
         assign prev_d = data_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_next
         assign next_d = data_w[g+1];
      end
      ple_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (g)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .at        (at),
         .wr_data   (value_ff),
         .prev_data (prev_d),
         .next_data (next_d),
         .data      (data_w[g]),
         .rd_data   (rd_w[g])
      );
   end

   // at most one leaf is nonzero
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | rd_w[i];
      end
   end

   assign rd_ext  = EXT_W'(rd_or);
   assign len_ext = LEXT_W'(count_ff);

   // response register
   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_length_in     = rsp_length_ff;
      rsp_is_empty_in   = rsp_is_empty_ff;
      if (rsp_load) begin
         rsp_valid_in      = 1'b1;
         rsp_read_value_in = rd_ext[VALUE_W-1:0];
         rsp_status_in     = status_ff;
         rsp_length_in     = len_ext[LEN_W-1:0];
         rsp_is_empty_in   = (count_ff == '0);
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_length_ff     <= rsp_length_in;
      rsp_is_empty_ff   <= rsp_is_empty_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_value = rsp_read_value_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.length     = rsp_length_ff;
   assign rsp_if.is_empty   = rsp_is_empty_ff;

   // checks
   `ASSERT_INV(a_count_bound, clock, reset, (CMP_W'(count_ff) <= CAP_C),
      "entry count above capacity")
   `ASSERT_CLK(a_accept_exec, clock, reset, req_accept |=> (state_ff == S_EXEC),
      "accepted transaction did not start execution")
   `ASSERT_CLK(a_full_status, clock, reset,
      ((state_ff == S_DONE) && (status_ff == ST_FULL)) |-> (CMP_W'(count_ff) == CAP_C),
      "full status with room left in the list")
   `ASSERT_CLK(a_bad_pos_keeps, clock, reset,
      ((state_ff == S_DONE) && (status_ff == ST_BAD_POS)) |-> (count_ff == $past(count_ff)),
      "rejected transaction changed the length")

endmodule
